[rtl/unix_seconds_to_calendar_unit_defines.svh]
// assertion macros for the unix seconds to calendar unit
`ifndef UNIX_SECONDS_TO_CALENDAR_UNIT_DEFINES_SVH
`define UNIX_SECONDS_TO_CALENDAR_UNIT_DEFINES_SVH

// plain property checked on every clock edge outside reset
`define US2CAL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define US2CAL_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define US2CAL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/us2cal_pkg.sv]
// constants and month table for the unix seconds to calendar unit
`timescale 1ns / 1ps
`default_nettype none

package us2cal_pkg;

   localparam int unsigned SecsWidth    = 32;
   localparam int unsigned DayShiftIn   = 7;
   localparam int unsigned PipeStages   = 6;

   localparam logic [25:0] DayRecip     = 26'd50903317;
   localparam logic [9:0]  DayDivisor   = 10'd675;
   localparam logic [16:0] EpochDays    = 17'd25567;
   localparam logic [17:0] HourRecip    = 18'd149131;
   localparam logic [11:0] SecsPerHour  = 12'd3600;
   localparam logic [12:0] MinRecip     = 13'd4370;
   localparam logic [5:0]  SecsPerMin   = 6'd60;
   localparam logic [17:0] YearRecip    = 18'd183860;
   localparam logic [8:0]  DaysPerYear  = 9'd365;
   localparam logic [17:0] WeekRecip    = 18'd149797;
   localparam logic [2:0]  DaysPerWeek  = 3'd7;

   localparam logic [3:0]  MonthsPerYear = 4'd12;
   localparam logic [4:0]  MaxHour       = 5'd23;
   localparam logic [5:0]  MaxMinSec     = 6'd59;
   localparam logic [2:0]  MaxWeekday    = 3'd6;

   function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] mon);
      logic [8:0] base;
      case (mon)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         4'd11:   base = 9'd334;
         default: base = 9'd0;
      endcase
      // leap years gain one day from march on
      if (leap && (mon >= 4'd2)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

`default_nettype wire

[rtl/unix_seconds_to_calendar_unit.sv]
// top level: unix seconds to broken-down calendar time, six stage pipeline
//
// usage
//   req channel: req_valid / req_stall carry one 32-bit unsigned seconds count per
//   transaction. rsp channel: rsp_valid / rsp_stall carry year since 1900, month,
//   day of month, hours, minutes, seconds and weekday (0 is sunday).
//   stages: a result reaches rsp_valid through one register stage per step
//   (day split, day remainder, reciprocal multiplies, year start, year fix-up
//   and minutes, month lookup and seconds).
//   throughput: one transaction per cycle, set by the full pipeline: every stage
//   takes a new transaction each cycle while the receiver does not stall.
//   the last stage is the output register; empty stages close up while the
//   receiver stalls, so requests keep being taken until all six stages hold data,
//   then req_stall rises. nothing is dropped or repeated under stall.
//   reset empties the pipeline; req_stall is high while reset is asserted.
`timescale 1ns / 1ps
`default_nettype none

module unix_seconds_to_calendar_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_unix_seconds,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_year_since_1900,
   output logic [3:0]       rsp_month,
   output logic [4:0]       rsp_day_of_month,
   output logic [4:0]       rsp_hours,
   output logic [5:0]       rsp_minutes,
   output logic [5:0]       rsp_seconds,
   output logic [2:0]       rsp_weekday
);

   localparam int unsigned NumStages = us2cal_pkg::PipeStages;

   logic [NumStages:1] valid_ff, valid_in;
   logic [NumStages:1] adv;

   // stage 1
   logic [24:0] s1_x_in, s1_x_ff;
   logic [15:0] s1_q_in, s1_q_ff;
   logic [6:0]  s1_low_in, s1_low_ff;
   logic [50:0] day_prod;

   // stage 2
   logic [16:0] s2_rem_in, s2_rem_ff;
   logic [16:0] s2_days_in, s2_days_ff;
   logic [24:0] day_back, day_diff;

   // stage 3
   logic [4:0]  s3_hours_in, s3_hours_ff;
   logic [7:0]  s3_y0_in, s3_y0_ff;
   logic [13:0] s3_wq_in, s3_wq_ff;
   logic [16:0] s3_rem_ff, s3_days_ff;
   logic [16:0] s3_wk_in, s3_wk_ff;
   logic [34:0] hour_prod, year_prod, week_prod;

   // stage 4
   logic [11:0] s4_rem2_in, s4_rem2_ff;
   logic [2:0]  s4_wday_in, s4_wday_ff;
   logic [16:0] s4_start_in, s4_start_ff;
   logic [7:0]  s4_y0_ff;
   logic [16:0] s4_days_ff;
   logic [4:0]  s4_hours_ff;
   logic [16:0] rem2_full, week_full;
   logic [7:0]  y0_less;
   logic [7:0]  leaps;

   // stage 5
   logic [7:0]  s5_year_in, s5_year_ff;
   logic [8:0]  s5_doy_in, s5_doy_ff;
   logic        s5_leap_in, s5_leap_ff;
   logic [5:0]  s5_mins_in, s5_mins_ff;
   logic [11:0] s5_rem2_ff;
   logic [2:0]  s5_wday_ff;
   logic [4:0]  s5_hours_ff;
   logic [23:0] min_prod;
   logic [7:0]  prev_year;
   logic        prev_leap, late;
   logic [16:0] prev_start, year_start;

   // stage 6
   logic [7:0]  s6_year_ff;
   logic [3:0]  s6_month_in, s6_month_ff;
   logic [4:0]  s6_dom_in, s6_dom_ff;
   logic [4:0]  s6_hours_ff;
   logic [5:0]  s6_mins_ff;
   logic [5:0]  s6_secs_in, s6_secs_ff;
   logic [2:0]  s6_wday_ff;
   logic [3:0]  mon_sel;
   logic [11:0] secs_full;

   // stage advance, bubbles close up under stall
   always_comb begin
      adv[NumStages] = !valid_ff[NumStages] || !rsp_stall;
      for (int k = NumStages - 1; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k + 1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (adv[1]) begin
         valid_in[1] = req_valid;
      end
      for (int k = 2; k <= NumStages; k++) begin
         if (adv[k]) begin
            valid_in[k] = valid_ff[k - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = reset || !adv[1];

   // stage 1: days since epoch by reciprocal multiply
   always_comb begin
      s1_x_in   = req_unix_seconds[us2cal_pkg::SecsWidth-1:us2cal_pkg::DayShiftIn];
      s1_low_in = req_unix_seconds[us2cal_pkg::DayShiftIn-1:0];
      day_prod  = 51'(s1_x_in) * 51'(us2cal_pkg::DayRecip);
      s1_q_in   = day_prod[50:35];
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_x_ff   <= s1_x_in;
         s1_q_ff   <= s1_q_in;
         s1_low_ff <= s1_low_in;
      end
   end

   // stage 2: seconds within the day and day count from 1900
   always_comb begin
      day_back   = 25'(s1_q_ff) * 25'(us2cal_pkg::DayDivisor);
      day_diff   = s1_x_ff - day_back;
      s2_rem_in  = {day_diff[9:0], s1_low_ff};
      s2_days_in = 17'(s1_q_ff) + us2cal_pkg::EpochDays;
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_rem_ff  <= s2_rem_in;
         s2_days_ff <= s2_days_in;
      end
   end

   // stage 3: hour, year estimate and week quotient
   always_comb begin
      hour_prod   = 35'(s2_rem_ff) * 35'(us2cal_pkg::HourRecip);
      s3_hours_in = hour_prod[33:29];
      year_prod   = 35'(s2_days_ff) * 35'(us2cal_pkg::YearRecip);
      s3_y0_in    = year_prod[33:26];
      s3_wk_in    = s2_days_ff + 17'd1;
      week_prod   = 35'(s3_wk_in) * 35'(us2cal_pkg::WeekRecip);
      s3_wq_in    = week_prod[33:20];
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_hours_ff <= s3_hours_in;
         s3_y0_ff    <= s3_y0_in;
         s3_wq_ff    <= s3_wq_in;
         s3_wk_ff    <= s3_wk_in;
         s3_rem_ff   <= s2_rem_ff;
         s3_days_ff  <= s2_days_ff;
      end
   end

   // stage 4: seconds within the hour, weekday, start of estimated year
   always_comb begin
      rem2_full   = s3_rem_ff - 17'(s3_hours_ff) * 17'(us2cal_pkg::SecsPerHour);
      s4_rem2_in  = rem2_full[11:0];
      week_full   = s3_wk_ff - 17'(s3_wq_ff) * 17'(us2cal_pkg::DaysPerWeek);
      s4_wday_in  = week_full[2:0];
      y0_less     = s3_y0_ff - 8'd1;
      leaps       = (s3_y0_ff == 8'd0) ? 8'd0 : {2'b00, y0_less[7:2]};
      s4_start_in = 17'(s3_y0_ff) * 17'(us2cal_pkg::DaysPerYear) + 17'(leaps);
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_rem2_ff  <= s4_rem2_in;
         s4_wday_ff  <= s4_wday_in;
         s4_start_ff <= s4_start_in;
         s4_y0_ff    <= s3_y0_ff;
         s4_days_ff  <= s3_days_ff;
         s4_hours_ff <= s3_hours_ff;
      end
   end

   // stage 5: year correction, day of year, minutes
   always_comb begin
      late       = s4_days_ff < s4_start_ff;
      prev_year  = s4_y0_ff - 8'd1;
      prev_leap  = (prev_year[1:0] == 2'b00) && (prev_year != 8'd0);
      prev_start = s4_start_ff - 17'(us2cal_pkg::DaysPerYear) - 17'(prev_leap);
      s5_year_in = late ? prev_year : s4_y0_ff;
      year_start = late ? prev_start : s4_start_ff;
      s5_doy_in  = 9'(s4_days_ff - year_start);
      s5_leap_in = (s5_year_in[1:0] == 2'b00) && (s5_year_in != 8'd0);
      min_prod   = 24'(s4_rem2_ff) * 24'(us2cal_pkg::MinRecip);
      s5_mins_in = min_prod[23:18];
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s5_year_ff  <= s5_year_in;
         s5_doy_ff   <= s5_doy_in;
         s5_leap_ff  <= s5_leap_in;
         s5_mins_ff  <= s5_mins_in;
         s5_rem2_ff  <= s4_rem2_ff;
         s5_wday_ff  <= s4_wday_ff;
         s5_hours_ff <= s4_hours_ff;
      end
   end

   // stage 6: month lookup, day of month, seconds
   always_comb begin
      mon_sel = 4'd0;
      for (int m = 1; m < 12; m++) begin
         if (s5_doy_ff >= us2cal_pkg::cum_days(s5_leap_ff, 4'(m))) begin
            mon_sel = 4'(m);
         end
      end
      s6_month_in = mon_sel + 4'd1;
      s6_dom_in   = 5'(s5_doy_ff - us2cal_pkg::cum_days(s5_leap_ff, mon_sel) + 9'd1);
      secs_full   = s5_rem2_ff - 12'(s5_mins_ff) * 12'(us2cal_pkg::SecsPerMin);
      s6_secs_in  = secs_full[5:0];
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s6_year_ff  <= s5_year_ff;
         s6_month_ff <= s6_month_in;
         s6_dom_ff   <= s6_dom_in;
         s6_hours_ff <= s5_hours_ff;
         s6_mins_ff  <= s5_mins_ff;
         s6_secs_ff  <= s6_secs_in;
         s6_wday_ff  <= s5_wday_ff;
      end
   end

   assign rsp_valid           = valid_ff[NumStages];
   assign rsp_year_since_1900 = s6_year_ff;
   assign rsp_month           = s6_month_ff;
   assign rsp_day_of_month    = s6_dom_ff;
   assign rsp_hours           = s6_hours_ff;
   assign rsp_minutes         = s6_mins_ff;
   assign rsp_seconds         = s6_secs_ff;
   assign rsp_weekday         = s6_wday_ff;

endmodule

`default_nettype wire

[rtl/us2cal_checker.sv]
// port checker for the unix seconds to calendar unit, with its bind
`timescale 1ns / 1ps
`default_nettype none
`include "unix_seconds_to_calendar_unit_defines.svh"

module us2cal_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_year_since_1900,
   input wire logic [3:0]  rsp_month,
   input wire logic [4:0]  rsp_day_of_month,
   input wire logic [4:0]  rsp_hours,
   input wire logic [5:0]  rsp_minutes,
   input wire logic [5:0]  rsp_seconds,
   input wire logic [2:0]  rsp_weekday
);

   logic req_take;
   logic fields_ok;

   assign req_take  = req_valid && !req_stall;
   assign fields_ok = (rsp_month != 4'd0) && (rsp_month <= us2cal_pkg::MonthsPerYear)
                   && (rsp_day_of_month != 5'd0) && (rsp_hours <= us2cal_pkg::MaxHour)
                   && (rsp_minutes <= us2cal_pkg::MaxMinSec)
                   && (rsp_seconds <= us2cal_pkg::MaxMinSec)
                   && (rsp_weekday <= us2cal_pkg::MaxWeekday)
                   && (rsp_year_since_1900 >= 8'd70);

   `US2CAL_ASSERT_IMPL(a_fields_in_range, clock, reset, rsp_valid, fields_ok, "rsp field out of range")

   `US2CAL_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_year_since_1900) && $stable(rsp_month) && $stable(rsp_day_of_month) && $stable(rsp_hours) && $stable(rsp_minutes) && $stable(rsp_seconds) && $stable(rsp_weekday), "stalled rsp changed")

   `US2CAL_ASSERT(a_empty_after_reset, clock, reset, !$past(reset) || !rsp_valid, "rsp valid right after reset")

   `US2CAL_ASSERT_IMPL(a_latency, clock, reset, $past(req_take && !reset, 6) && $past(!rsp_stall && !reset, 1) && $past(!rsp_stall && !reset, 2) && $past(!rsp_stall && !reset, 3) && $past(!rsp_stall && !reset, 4) && $past(!rsp_stall && !reset, 5), rsp_valid, "transaction not delivered after six cycles")

endmodule

bind unix_seconds_to_calendar_unit us2cal_checker u_us2cal_checker (.*);

`default_nettype wire
